// ===== design/csvp_pkg.sv =====
package csvp_pkg;

  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_EMIT      = 2'd1;
  localparam logic [1:0] CMD_EMIT_LINE = 2'd2;
  localparam logic [1:0] CMD_LINE      = 2'd3;

  localparam logic [7:0] SEP_CH   = 8'h2c;
  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] CR_CH    = 8'h0d;
  localparam logic [7:0] LF_CH    = 8'h0a;
  localparam logic [7:0] NUL_CH   = 8'h00;

  localparam logic [4:0] MAX_LIMIT   = 5'd16;
  localparam logic [4:0] LIMIT_RESET = 5'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] idx;
    logic [4:0] cnt;
  } cmd_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

// ===== design/csvp_front.sv =====
module csvp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_byte,
  input  logic [4:0]        field_limit,
  input  logic              q_full,
  output logic              q_push,
  output csvp_pkg::cmd_t    q_cmd
);
  import csvp_pkg::*;

  localparam logic [2:0] M_START  = 3'd0;
  localparam logic [2:0] M_PLAIN  = 3'd1;
  localparam logic [2:0] M_QUOTED = 3'd2;
  localparam logic [2:0] M_QPEND  = 3'd3;
  localparam logic [2:0] M_SKIP   = 3'd4;
  localparam logic [2:0] M_OVER   = 3'd5;

  logic [2:0] mode, mode_next;
  logic [4:0] field_number, field_number_next;
  logic [4:0] limit;
  logic       push_req;
  logic       is_eol_ch;
  logic       accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign limit     = (field_limit > MAX_LIMIT) ? MAX_LIMIT : field_limit;
  assign is_eol_ch = (in_byte == CR_CH) || (in_byte == LF_CH);
  assign q_push    = accept && push_req;

  always_comb begin
    mode_next         = mode;
    field_number_next = field_number;
    push_req          = 1'b0;
    q_cmd.kind        = CMD_ADD;
    q_cmd.data        = in_byte;
    q_cmd.idx         = field_number[3:0];
    q_cmd.cnt         = field_number;
    if (in_op) begin
      push_req = 1'b1;
      if ((mode != M_START) && (mode != M_OVER)) begin
        q_cmd.kind = CMD_EMIT_LINE;
        q_cmd.cnt  = field_number + 5'd1;
      end else begin
        q_cmd.kind = CMD_LINE;
      end
      field_number_next = '0;
      mode_next         = M_START;
    end else if (in_byte != NUL_CH) begin
      case (mode)
        M_START: begin
          if ((field_number >= limit) || is_eol_ch) begin
            mode_next = M_OVER;
          end else if (in_byte == SEP_CH) begin
            push_req          = 1'b1;
            q_cmd.kind        = CMD_EMIT;
            field_number_next = field_number + 5'd1;
          end else if (in_byte == QUOTE_CH) begin
            mode_next = M_QUOTED;
          end else begin
            push_req  = 1'b1;
            mode_next = M_PLAIN;
          end
        end
        M_PLAIN: begin
          if ((in_byte == SEP_CH) || is_eol_ch) begin
            push_req          = 1'b1;
            q_cmd.kind        = CMD_EMIT;
            field_number_next = field_number + 5'd1;
            mode_next         = (in_byte == SEP_CH) ? M_START : M_OVER;
          end else begin
            push_req = 1'b1;
          end
        end
        M_QUOTED: begin
          if (in_byte == QUOTE_CH) begin
            mode_next = M_QPEND;
          end else begin
            push_req = 1'b1;
          end
        end
        M_QPEND, M_SKIP: begin
          if ((mode == M_QPEND) && (in_byte == QUOTE_CH)) begin
            push_req  = 1'b1;
            mode_next = M_QUOTED;
          end else if ((in_byte == SEP_CH) || is_eol_ch) begin
            push_req          = 1'b1;
            q_cmd.kind        = CMD_EMIT;
            field_number_next = field_number + 5'd1;
            mode_next         = (in_byte == SEP_CH) ? M_START : M_OVER;
          end else begin
            mode_next = M_SKIP;
          end
        end
        default: begin
          mode_next = M_OVER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_START;
      field_number <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      field_number <= field_number_next;
    end
  end

endmodule

// ===== design/csvp_fifo.sv =====
module csvp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvp_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output csvp_pkg::cmd_t    pop_cmd
);
  import csvp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/csvp_back.sv =====
module csvp_back #(
  parameter int BUF_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  csvp_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,  // chunk, chunk_bytes, field_index, field_end, field_count
  output logic [0:0]        m_tuser,  // line_done
  output logic              m_tlast
);
  import csvp_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);
  localparam logic [AW-1:0] RAW_MAX = AW'(BUF_BYTES - 2);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_WAIT = 2'd2;
  localparam logic [1:0] B_PUSH = 2'd3;

  logic [7:0]    mem [BUF_BYTES];
  logic [7:0]    mem_q;
  logic          wr_en;

  logic [1:0]    bst;
  logic [AW-1:0] raw_length, first_pos, last_pos;
  logic          has_text;
  logic [AW-1:0] rd_pos, rd_end, rem_next, rem_first;
  logic [2:0]    lane_iss, rd_lane;
  logic [3:0]    chunk_n;
  logic          rd_vld;
  logic          emitting, line_pend;
  logic [4:0]    line_cnt;
  logic          out_free;

  logic [63:0]   res_chunk;
  logic [3:0]    res_nb;
  logic [3:0]    res_idx;
  logic          res_fend, res_ldone, res_last;
  logic [4:0]    res_cnt;

  assign q_pop     = (bst == B_IDLE) && q_avail;
  assign wr_en     = q_pop && (q_cmd.kind == CMD_ADD) && (raw_length < RAW_MAX);
  assign out_free  = !m_tvalid || m_tready;
  assign rem_next  = rd_end - rd_pos;
  assign rem_first = last_pos + AW'(1) - first_pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[raw_length] <= q_cmd.data;
    end
    mem_q <= mem[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst        <= B_IDLE;
      raw_length <= '0;
      first_pos  <= '0;
      last_pos   <= '0;
      has_text   <= 1'b0;
      rd_vld     <= 1'b0;
      emitting   <= 1'b0;
      line_pend  <= 1'b0;
      m_tvalid   <= 1'b0;
      rd_pos     <= '0;
    end else begin
      rd_vld <= (bst == B_READ);
      if (m_tvalid && m_tready && (bst != B_PUSH)) begin
        m_tvalid <= 1'b0;
      end
      if (rd_vld) begin
        res_chunk[rd_lane*8 +: 8] <= mem_q;
      end
      case (bst)
        B_IDLE: begin
          if (q_pop) begin
            case (q_cmd.kind)
              CMD_ADD: begin
                if (raw_length < RAW_MAX) begin
                  if (!is_space(q_cmd.data)) begin
                    if (!has_text) begin
                      first_pos <= raw_length;
                    end
                    last_pos <= raw_length;
                    has_text <= 1'b1;
                  end
                  raw_length <= raw_length + AW'(1);
                end
              end
              CMD_EMIT, CMD_EMIT_LINE: begin
                line_pend  <= (q_cmd.kind == CMD_EMIT_LINE);
                line_cnt   <= q_cmd.cnt;
                res_idx    <= q_cmd.idx;
                res_ldone  <= 1'b0;
                res_cnt    <= '0;
                raw_length <= '0;
                first_pos  <= '0;
                last_pos   <= '0;
                has_text   <= 1'b0;
                res_chunk  <= '0;
                if (has_text) begin
                  emitting <= 1'b1;
                  rd_pos   <= first_pos;
                  rd_end   <= last_pos + AW'(1);
                  chunk_n  <= (rem_first > AW'(8)) ? 4'd8 : rem_first[3:0];
                  lane_iss <= '0;
                  bst      <= B_READ;
                end else begin
                  emitting <= 1'b0;
                  res_nb   <= '0;
                  res_fend <= 1'b1;
                  res_last <= (q_cmd.kind != CMD_EMIT_LINE);
                  bst      <= B_PUSH;
                end
              end
              default: begin
                line_pend <= 1'b0;
                emitting  <= 1'b0;
                res_chunk <= '0;
                res_nb    <= '0;
                res_idx   <= '0;
                res_fend  <= 1'b0;
                res_ldone <= 1'b1;
                res_cnt   <= q_cmd.cnt;
                res_last  <= 1'b1;
                bst       <= B_PUSH;
              end
            endcase
          end
        end
        B_READ: begin
          rd_lane  <= lane_iss;
          rd_pos   <= rd_pos + AW'(1);
          lane_iss <= lane_iss + 3'd1;
          if ({1'b0, lane_iss} == (chunk_n - 4'd1)) begin
            bst <= B_WAIT;
          end
        end
        B_WAIT: begin
          res_nb    <= chunk_n;
          res_fend  <= (rd_pos == rd_end);
          res_last  <= (rd_pos == rd_end) && !line_pend;
          res_ldone <= 1'b0;
          res_cnt   <= '0;
          bst       <= B_PUSH;
        end
        default: begin
          if (out_free) begin
            m_tvalid             <= 1'b1;
            m_tdata[63:0]        <= res_chunk;
            m_tdata[67:64]       <= res_nb;
            m_tdata[71:68]       <= res_idx;
            m_tdata[72]          <= res_fend;
            m_tdata[77:73]       <= res_cnt;
            m_tdata[79:78]       <= '0;
            m_tuser[0]           <= res_ldone;
            m_tlast              <= res_last;
            if (emitting && (rd_pos != rd_end)) begin
              res_chunk <= '0;
              chunk_n   <= (rem_next > AW'(8)) ? 4'd8 : rem_next[3:0];
              lane_iss  <= '0;
              bst       <= B_READ;
            end else if (line_pend) begin
              emitting  <= 1'b0;
              line_pend <= 1'b0;
              res_chunk <= '0;
              res_nb    <= '0;
              res_idx   <= '0;
              res_fend  <= 1'b0;
              res_ldone <= 1'b1;
              res_cnt   <= line_cnt;
              res_last  <= 1'b1;
            end else begin
              emitting <= 1'b0;
              bst      <= B_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== design/csv_field_parser.sv =====
// flow: a closing byte queues an emit command; the back end reads the field's trimmed
//   bytes from the store and registers them on the output in chunks of up to 8; an
//   empty field or a lone line result is registered without store reads
// throughput: one input byte per cycle while the command queue has room
// reset: synchronous active-high rst clears parse state, queue and output valid,
//   the field limit returns to 3; field store contents are not cleared
module csv_field_parser #(
  parameter int BUF_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte
  input  logic [0:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // chunk, chunk_bytes, field_index, field_end, field_count
  output logic [0:0]  m_tuser,   // line_done
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // field limit
);
  import csvp_pkg::*;

  logic [4:0] field_limit;
  logic       q_full, q_push, q_avail, q_pop;
  cmd_t       push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      field_limit <= cfg_data;
    end
  end

  csvp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser[0]),
    .in_byte     (s_tdata),
    .field_limit (field_limit),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  csvp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_cmd  (pop_cmd)
  );

  csvp_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/csvp_check.sv =====
module csvp_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  a_line_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata[72:0] == 73'd0))
    else $error("line result not last or carries chunk data");

  a_nb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[67:64] <= 4'd8) && (m_tdata[77:73] == 5'd0))
    else $error("bad chunk byte count or count on chunk");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[72] || m_tuser[0])
    else $error("last result is not a field end or line end");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[77:73] <= 5'd16)
    else $error("field count above sixteen");

endmodule

bind csv_field_parser csvp_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
